// ===== src/depth_bilateral_filter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// depth bilateral filter assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef DEPTH_BILATERAL_FILTER_UNIT_MACROS_SVH
`define DEPTH_BILATERAL_FILTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define DBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dbf_pkg.sv =====
// ----------------------------------------------------------------------------
// dbf_pkg
// types, constants and the weight table function of the depth bilateral filter
// ----------------------------------------------------------------------------
package dbf_pkg;

   localparam int FD_W     = 16;
   localparam int ROW_W    = 9;
   localparam int COL_W    = 10;
   // spatial term and column offset sized for the largest radius (7)
   localparam int SP_W     = 7;
   localparam int OFS_W    = 3;
   localparam int KEY_W    = 15;
   localparam int KEY_SPAN = 32768;
   localparam int DD_LIMIT = 182;
   localparam int SP_SCALE = 100;

   localparam logic [63:0] EINV_Q32 = 64'd1580030169;

   localparam logic [1:0] REG_ENABLE = 2'd0;
   localparam logic [1:0] REG_COLS   = 2'd1;
   localparam logic [1:0] REG_ROWS   = 2'd2;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   typedef struct packed {
      logic             action;
      logic [FD_W-1:0]  depth;
      logic             valid_req;
   } dbf_req_type;

   typedef struct packed {
      logic [FD_W-1:0]  filtered_depth;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             last;
   } dbf_rsp_type;

   typedef struct packed {
      logic             wr;
      logic             pos_clr;
      logic             cen_rd;
      logic             cen_lat;
      logic             row_up;
      logic             row_start;
      logic [OFS_W-1:0] col_ofs;
      logic             nb_rd;
      logic [SP_W-1:0]  sp;
      logic             row_next;
      logic             acc_clr;
      logic             div_start;
      logic             emit_adv;
      logic             load_out;
      logic             pass;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             last;
   } dbf_cmd_type;

   typedef struct packed {
      logic cen_valid;
      logic pipe_idle;
      logic div_done;
      logic out_free;
   } dbf_sts_type;

   // exp(-t) scaled to 65535, t given in q32; evaluated at elaboration only
   function automatic logic [FD_W-1:0] exp_weight(input logic [63:0] tq);
      logic [63:0] n;
      logic [63:0] f;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] res;
      n    = tq >> 32;
      f    = tq & 64'hFFFF_FFFF;
      sum  = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int k = 1; k <= 13; k++) begin
         term = ((term * f) >> 32) / 64'(k);
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      for (int j = 0; j < 20; j++) begin
         if (64'(j) < n) sum = (sum * EINV_Q32) >> 32;
      end
      res = (sum * 64'd65535 + (64'd1 << 31)) >> 32;
      return res[FD_W-1:0];
   endfunction

endpackage

// ===== src/depth_bilateral_filter_unit.sv =====
// ----------------------------------------------------------------------------
// depth_bilateral_filter_unit
// streaming bilateral filter for depth frames with a line store
// ----------------------------------------------------------------------------
// Depth pixels enter in raster order on the req channel, each with its own
// valid bit, and are written into a line store of (2*RADIUS+1)*MAX_COLS
// entries. Once a pixel's whole window has arrived (RADIUS rows and RADIUS
// pixels later) one result leaves on the rsp channel: the weighted mean of the
// valid neighbours in the window clipped at the frame edges, weights from a
// table indexed by spatial and depth distance, rounded to nearest. An invalid
// centre or a disabled filter gives the raw depth. Drain transfers after the
// frame flush the last RADIUS rows; a pixel sent after the frame is complete
// and a drain sent before it are dropped without a result. Items are handled
// one at a time. Filtering speed is set by the single read port of the line
// store, which fetches one neighbour a cycle, and by the 16-step divider at
// the end. A finished result sits in an output register, so the next item is
// taken while it waits. Writes to frame_cols or frame_rows restart the frame.
// The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "depth_bilateral_filter_unit_macros.svh"

module depth_bilateral_filter_unit import dbf_pkg::*; #(
   parameter int RADIUS             = 5,
   parameter int MAX_COLS           = 640,
   parameter int WEIGHT_TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input transfers
   input  logic        req_valid,
   output logic        req_ready,
   input  dbf_req_type req_data,
   // result transfers
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dbf_rsp_type rsp_data,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic             filter_enable_ff;
   logic [COL_W-1:0] frame_cols_ff;
   logic [ROW_W-1:0] frame_rows_ff;
   logic             cfg_wr, cfg_clr;
   logic [1:0]       reg_sel;
   logic [COL_W-1:0] cols;
   logic [ROW_W-1:0] rows;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite && pready;
   // a geometry write aborts the frame in progress
   assign cfg_clr = cfg_wr && (reg_sel == REG_COLS || reg_sel == REG_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         frame_cols_ff    <= COL_W'(640);
         frame_rows_ff    <= ROW_W'(480);
      end else if (cfg_wr) begin
         case (reg_sel)
            REG_ENABLE: filter_enable_ff <= pwdata[0];
            REG_COLS:   frame_cols_ff    <= pwdata[COL_W-1:0];
            REG_ROWS:   frame_rows_ff    <= pwdata[ROW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ENABLE: prdata = 32'(filter_enable_ff);
         REG_COLS:   prdata = 32'(frame_cols_ff);
         REG_ROWS:   prdata = 32'(frame_rows_ff);
         default:    prdata = '0;
      endcase
   end

   // geometry in use: columns clamped to the line store width, zero taken as one
   always_comb begin
      if (frame_cols_ff == '0) cols = COL_W'(1);
      else if (32'(frame_cols_ff) > MAX_COLS) cols = COL_W'(MAX_COLS);
      else cols = frame_cols_ff;
      rows = (frame_rows_ff == '0) ? ROW_W'(1) : frame_rows_ff;
   end

   dbf_cmd_type cmd;
   dbf_sts_type sts;

   // sequencer: frame position, emit decision and window walk
   dbf_ctrl #(
      .RADIUS (RADIUS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg_clr   (cfg_clr),
      .enable    (filter_enable_ff),
      .rows      (rows),
      .cols      (cols),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: line store, weight pipeline, divider and output register
   dbf_dpath #(
      .RADIUS             (RADIUS),
      .MAX_COLS           (MAX_COLS),
      .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cols      (cols),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // the store is written only on an accepted pixel transfer
   `DBF_ASSERT_NOW(a_wr_on_transfer, clock, reset, cmd.wr, req_valid && req_ready && req_data.action == ACT_PIXEL, "line store written without a pixel transfer")
   // a result is never loaded over one that is still waiting
   `DBF_ASSERT_NOW(a_load_free, clock, reset, cmd.load_out, sts.out_free, "result register overwritten")
   // the divider starts only once every neighbour has been summed
   `DBF_ASSERT_NOW(a_div_after_pipe, clock, reset, cmd.div_start, sts.pipe_idle, "divide started with neighbours in flight")
   // a loaded result shows up as valid in the following cycle
   `DBF_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_out, rsp_valid, "loaded result not presented")

endmodule

// ===== src/dbf_ram.sv =====
// ----------------------------------------------------------------------------
// dbf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dbf_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 7040
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbf_ctrl
// frame position counters and the sequencer that walks each output window
// ----------------------------------------------------------------------------
module dbf_ctrl import dbf_pkg::*; #(
   parameter int RADIUS = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dbf_req_type       req_data,
   input  logic              cfg_clr,
   input  logic              enable,
   input  logic [ROW_W-1:0]  rows,
   input  logic [COL_W-1:0]  cols,
   input  dbf_sts_type       sts,
   output dbf_cmd_type       cmd
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CEN   = 4'd1;
   localparam logic [3:0] ST_CWAIT = 4'd2;
   localparam logic [3:0] ST_UP    = 4'd3;
   localparam logic [3:0] ST_ROW   = 4'd4;
   localparam logic [3:0] ST_COLS  = 4'd5;
   localparam logic [3:0] ST_DRAIN = 4'd6;
   localparam logic [3:0] ST_DIV   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   localparam int PEND_W = ROW_W + COL_W;
   localparam logic [OFS_W-1:0] R_OFS = OFS_W'(RADIUS);

   logic [3:0]       state_ff, state_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] emit_row_ff, emit_row_in;
   logic [COL_W-1:0] emit_col_ff, emit_col_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic             pass_ff, pass_in;
   logic [OFS_W-1:0] up_cnt_ff, up_cnt_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic [ROW_W-1:0] kr_ff, kr_in;
   logic [ROW_W-1:0] r1_ff, r1_in;
   logic [COL_W-1:0] l_ff, l_in;
   logic [COL_W-1:0] c0_ff, c0_in;
   logic [COL_W-1:0] c1_ff, c1_in;

   logic              complete, complete_n, is_pix, col_wrap, go, is_last;
   logic [COL_W:0]    col_nx;
   logic [ROW_W-1:0]  row_nx;
   logic [PEND_W-1:0] lag, pend_nx;
   logic [ROW_W:0]    er_hi;
   logic [COL_W:0]    ec_hi;
   logic [ROW_W-1:0]  dr_full;
   logic [COL_W-1:0]  dc_full;
   logic [OFS_W-1:0]  dr, dc, er_ofs, ec_ofs;

   assign lag = PEND_W'(RADIUS) * PEND_W'(cols) + PEND_W'(RADIUS);

   always_comb begin
      complete   = in_row_ff >= rows;
      is_pix     = req_data.action == ACT_PIXEL;
      col_nx     = {1'b0, in_col_ff} + 1'b1;
      col_wrap   = col_nx >= {1'b0, cols};
      row_nx     = in_row_ff + ROW_W'(col_wrap);
      complete_n = row_nx >= rows;
      pend_nx    = pending_ff + 1'b1;
      go = (is_pix && !complete && (complete_n || pend_nx > lag)) ||
           (!is_pix && complete);
      is_last = (emit_row_ff == rows - 1'b1) && (emit_col_ff == cols - 1'b1);
      er_ofs  = (emit_row_ff < ROW_W'(RADIUS)) ? emit_row_ff[OFS_W-1:0] : R_OFS;
      ec_ofs  = (emit_col_ff < COL_W'(RADIUS)) ? emit_col_ff[OFS_W-1:0] : R_OFS;
      er_hi   = {1'b0, emit_row_ff} + (ROW_W+1)'(RADIUS);
      ec_hi   = {1'b0, emit_col_ff} + (COL_W+1)'(RADIUS);
      dr_full = (kr_ff > emit_row_ff) ? kr_ff - emit_row_ff : emit_row_ff - kr_ff;
      dc_full = (l_ff > emit_col_ff) ? l_ff - emit_col_ff : emit_col_ff - l_ff;
      dr      = dr_full[OFS_W-1:0];
      dc      = dc_full[OFS_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      pending_in  = pending_ff;
      pass_in     = pass_ff;
      up_cnt_in   = up_cnt_ff;
      ofs_in      = ofs_ff;
      kr_in       = kr_ff;
      r1_in       = r1_ff;
      l_in        = l_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      cmd         = '0;
      cmd.col_ofs = ofs_ff;
      cmd.sp      = SP_W'(dr) * SP_W'(dr) + SP_W'(dc) * SP_W'(dc);
      cmd.pass    = pass_ff;
      cmd.row     = emit_row_ff;
      cmd.col     = emit_col_ff;
      cmd.last    = is_last;
      req_ready   = state_ff == ST_IDLE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (is_pix && !complete) begin
                  cmd.wr     = 1'b1;
                  in_col_in  = col_wrap ? '0 : col_nx[COL_W-1:0];
                  in_row_in  = row_nx;
                  pending_in = pend_nx;
               end
               if (go) state_in = ST_CEN;
            end
         end
         ST_CEN: begin
            cmd.cen_rd = 1'b1;
            state_in   = ST_CWAIT;
         end
         ST_CWAIT: begin
            cmd.cen_lat = 1'b1;
            if (!enable || !sts.cen_valid) begin
               pass_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               pass_in     = 1'b0;
               cmd.acc_clr = 1'b1;
               up_cnt_in   = er_ofs;
               kr_in       = emit_row_ff - ROW_W'(er_ofs);
               r1_in       = (er_hi > {1'b0, rows - 1'b1}) ? rows - 1'b1
                                                           : er_hi[ROW_W-1:0];
               ofs_in      = ec_ofs;
               c0_in       = emit_col_ff - COL_W'(ec_ofs);
               c1_in       = (ec_hi > {1'b0, cols - 1'b1}) ? cols - 1'b1
                                                           : ec_hi[COL_W-1:0];
               state_in    = ST_UP;
            end
         end
         ST_UP: begin
            if (up_cnt_ff == '0) begin
               state_in = ST_ROW;
            end else begin
               cmd.row_up = 1'b1;
               up_cnt_in  = up_cnt_ff - 1'b1;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            l_in          = c0_ff;
            state_in      = ST_COLS;
         end
         ST_COLS: begin
            cmd.nb_rd = 1'b1;
            if (l_ff == c1_ff) begin
               if (kr_ff == r1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  cmd.row_next = 1'b1;
                  kr_in        = kr_ff + 1'b1;
                  state_in     = ST_ROW;
               end
            end else begin
               l_in = l_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (sts.pipe_idle) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
               if (is_last) begin
                  cmd.pos_clr = 1'b1;
                  in_row_in   = '0;
                  in_col_in   = '0;
                  emit_row_in = '0;
                  emit_col_in = '0;
                  pending_in  = '0;
               end else begin
                  cmd.emit_adv = 1'b1;
                  pending_in   = pending_ff - 1'b1;
                  if (emit_col_ff == cols - 1'b1) begin
                     emit_col_in = '0;
                     emit_row_in = emit_row_ff + 1'b1;
                  end else begin
                     emit_col_in = emit_col_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // frame geometry change restarts the frame
      if (cfg_clr) begin
         cmd.pos_clr = 1'b1;
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
         pending_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         emit_row_ff <= '0;
         emit_col_ff <= '0;
         pending_ff  <= '0;
         pass_ff     <= 1'b0;
         up_cnt_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
         pending_ff  <= pending_in;
         pass_ff     <= pass_in;
         up_cnt_ff   <= up_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ofs_ff <= ofs_in;
      kr_ff  <= kr_in;
      r1_ff  <= r1_in;
      l_ff   <= l_in;
      c0_ff  <= c0_in;
      c1_ff  <= c1_in;
   end

endmodule

// ===== src/dbf_dpath.sv =====
// ----------------------------------------------------------------------------
// dbf_dpath
// line store addressing, weight pipeline, accumulators, divider, output stage
// ----------------------------------------------------------------------------
module dbf_dpath import dbf_pkg::*; #(
   parameter int RADIUS             = 5,
   parameter int MAX_COLS           = 640,
   parameter int WEIGHT_TABLE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  dbf_cmd_type      cmd,
   output dbf_sts_type      sts,
   input  logic [COL_W-1:0] cols,
   input  dbf_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dbf_rsp_type      rsp_data
);

   localparam int STORE_DEPTH = (2 * RADIUS + 1) * MAX_COLS;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int WIN         = (2 * RADIUS + 1) * (2 * RADIUS + 1);
   localparam int SW_W        = FD_W + $clog2(WIN + 1);
   localparam int SWD_W       = SW_W + FD_W;
   localparam int IW          = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int CNT_W       = $clog2(FD_W + 1);
   localparam int KEY_FULL_W  = KEY_W + 2;
   localparam logic [AW:0] STORE_LIM = (AW+1)'(STORE_DEPTH);

   function automatic logic [AW-1:0] add_mod(input logic [AW-1:0] a, input logic [AW:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + b;
      if (s >= STORE_LIM) s = s - STORE_LIM;
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW:0] b);
      logic [AW:0] s;
      if ({1'b0, a} >= b) s = {1'b0, a} - b;
      else s = {1'b0, a} + STORE_LIM - b;
      return s[AW-1:0];
   endfunction

   // weight table, one entry per key bucket
   logic [FD_W-1:0] rom_tbl [WEIGHT_TABLE_DEPTH];
   for (genvar gi = 0; gi < WEIGHT_TABLE_DEPTH; gi++) begin : g_rom
      localparam logic [63:0] TQ = ((64'(gi) * 64'(KEY_SPAN)) << 32) /
                                   (64'd1800 * 64'(WEIGHT_TABLE_DEPTH));
      assign rom_tbl[gi] = exp_weight(TQ);
   end

   logic [AW-1:0]  in_addr_ff, emit_addr_ff, base_ff, ptr_ff;
   logic [AW-1:0]  rd_addr;
   logic [FD_W:0]  rd_data;
   logic [FD_W-1:0] cd_ff;

   dbf_ram #(
      .WIDTH (FD_W + 1),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.wr),
      .wr_addr (in_addr_ff),
      .wr_data ({req_data.valid_req, req_data.depth}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = cmd.cen_rd ? emit_addr_ff : ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_addr_ff   <= '0;
         emit_addr_ff <= '0;
      end else if (cmd.pos_clr) begin
         in_addr_ff   <= '0;
         emit_addr_ff <= '0;
      end else begin
         if (cmd.wr) in_addr_ff <= add_mod(in_addr_ff, (AW+1)'(1));
         if (cmd.emit_adv) emit_addr_ff <= add_mod(emit_addr_ff, (AW+1)'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cen_rd) base_ff <= emit_addr_ff;
      else if (cmd.row_up) base_ff <= sub_mod(base_ff, (AW+1)'(cols));
      else if (cmd.row_next) base_ff <= add_mod(base_ff, (AW+1)'(cols));
      if (cmd.row_start) ptr_ff <= sub_mod(base_ff, (AW+1)'(cmd.col_ofs));
      else if (cmd.nb_rd) ptr_ff <= add_mod(ptr_ff, (AW+1)'(1));
      if (cmd.cen_lat) cd_ff <= rd_data[FD_W-1:0];
   end

   // weight pipeline
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [SP_W-1:0]       sp1_ff;
   logic [FD_W-1:0]       nd2_ff, nd3_ff;
   logic [KEY_W-1:0]      key2_ff;
   logic                  ok2_ff;
   logic [FD_W-1:0]       w3_ff, w4_ff;
   logic [2*FD_W-1:0]     prod4_ff;
   logic [FD_W-1:0]       nd, dd;
   logic [7:0]            dd8;
   logic [KEY_FULL_W-1:0] key;
   logic                  key_ok;
   logic [KEY_W+IW:0]     idx_prod;
   logic [IW-1:0]         idx;

   always_comb begin
      nd       = rd_data[FD_W-1:0];
      dd       = (nd > cd_ff) ? nd - cd_ff : cd_ff - nd;
      dd8      = dd[7:0];
      key      = KEY_FULL_W'(sp1_ff) * KEY_FULL_W'(SP_SCALE) +
                 KEY_FULL_W'(dd8) * KEY_FULL_W'(dd8);
      key_ok   = (dd < FD_W'(DD_LIMIT)) && (key < KEY_FULL_W'(KEY_SPAN));
      idx_prod = (KEY_W+IW+1)'(key2_ff) * (KEY_W+IW+1)'(WEIGHT_TABLE_DEPTH);
      idx      = idx_prod[KEY_W +: IW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.nb_rd;
         v2_ff <= v1_ff & rd_data[FD_W];
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      sp1_ff   <= cmd.sp;
      nd2_ff   <= nd;
      key2_ff  <= key[KEY_W-1:0];
      ok2_ff   <= key_ok;
      nd3_ff   <= nd2_ff;
      w3_ff    <= ok2_ff ? rom_tbl[idx] : '0;
      prod4_ff <= w3_ff * nd3_ff;
      w4_ff    <= w3_ff;
   end

   // accumulators
   logic [SW_W-1:0]  sw_ff;
   logic [SWD_W-1:0] swd_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         sw_ff  <= '0;
         swd_ff <= '0;
      end else if (v4_ff) begin
         sw_ff  <= sw_ff + SW_W'(w4_ff);
         swd_ff <= swd_ff + SWD_W'(prod4_ff);
      end
   end

   // restoring divider, one quotient bit a cycle
   logic [CNT_W-1:0] div_cnt_ff;
   logic [SW_W-1:0]  rem_ff;
   logic [FD_W-1:0]  lo_ff, q_ff;
   logic [SWD_W-1:0] num;
   logic [SW_W:0]    trial, trial_sub;
   logic             ge;

   always_comb begin
      num       = swd_ff + SWD_W'(sw_ff >> 1);
      trial     = {rem_ff, lo_ff[FD_W-1]};
      ge        = trial >= {1'b0, sw_ff};
      trial_sub = trial - {1'b0, sw_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= CNT_W'(FD_W);
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= num[SWD_W-1:FD_W];
         lo_ff  <= num[FD_W-1:0];
         q_ff   <= '0;
      end else if (div_cnt_ff != '0) begin
         rem_ff <= ge ? trial_sub[SW_W-1:0] : trial[SW_W-1:0];
         lo_ff  <= {lo_ff[FD_W-2:0], 1'b0};
         q_ff   <= {q_ff[FD_W-2:0], ge};
      end
   end

   // output register
   logic        rsp_valid_ff;
   dbf_rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.filtered_depth <= cmd.pass ? cd_ff : q_ff;
         rsp_data_ff.out_row        <= cmd.row;
         rsp_data_ff.out_col        <= cmd.col;
         rsp_data_ff.last           <= cmd.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign sts.cen_valid = rd_data[FD_W];
   assign sts.pipe_idle = !(v1_ff || v2_ff || v3_ff || v4_ff);
   assign sts.div_done  = div_cnt_ff == '0;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

// ===== sim/depth_bilateral_filter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// depth_bilateral_filter_unit_tb
// self-checking bench for the streaming depth bilateral filter
// ----------------------------------------------------------------------------
// Frames of many sizes are streamed in raster order through the req channel.
// Each frame is followed by drain transfers, and now and then a frame is cut
// short by a register write. Out-of-place pixels and drains are mixed in as
// noise. A scoreboard keeps its own line store, weight table and position
// counters. For each accepted transfer that yields a result it works out the
// expected filtered pixel and checks it field by field against the rsp channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module depth_bilateral_filter_unit_tb;
   import dbf_pkg::*;

   localparam int RAD       = 5;
   localparam int MAXC      = 640;
   localparam int WT_DEPTH  = 256;
   localparam int STORE_LEN = (2 * RAD + 1) * MAXC;
   localparam int LIMIT     = 4000000;
   localparam int SETTLE    = 400;
   localparam int RAND_ITEMS = 1600;

   // ---------------------------------------------------------------------
   // scoreboard: predicts filtered pixels and checks them in order
   // ---------------------------------------------------------------------
   class filter_scoreboard;
      logic [16:0]   pix_mem [STORE_LEN];
      logic [15:0]   wt_rom [WT_DEPTH];
      int unsigned   row_in, col_in, row_out, col_out;
      bit            enable;
      int unsigned   cols_reg, rows_reg;
      dbf_rsp_type   expected_pixels [$];
      int            errors;
      int            frames_done;

      function new();
         logic [63:0] tq, n, f, acc, term;
         for (int i = 0; i < WT_DEPTH; i++) begin
            tq   = ((64'(i) * 64'd32768) << 32) / (64'd1800 * 64'(WT_DEPTH));
            n    = tq >> 32;
            f    = tq & 64'hFFFF_FFFF;
            acc  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int k = 1; k <= 13; k++) begin
               term = ((term * f) >> 32) / 64'(k);
               if (k & 1) acc = acc - term;
               else acc = acc + term;
            end
            for (logic [63:0] j = 0; j < n; j++) acc = (acc * 64'd1580030169) >> 32;
            wt_rom[i] = 16'((acc * 64'd65535 + (64'd1 << 31)) >> 32);
         end
         foreach (pix_mem[i]) pix_mem[i] = '0;
         row_in = 0; col_in = 0; row_out = 0; col_out = 0;
         enable = 0; cols_reg = 640; rows_reg = 480;
         errors = 0; frames_done = 0;
      endfunction

      function int unsigned ncols();
         return cols_reg < 1 ? 1 : (cols_reg > MAXC ? MAXC : cols_reg);
      endfunction

      function int unsigned nrows();
         return rows_reg < 1 ? 1 : rows_reg;
      endfunction

      function bit input_done();
         return row_in >= nrows();
      endfunction

      function void restart();
         row_in = 0; col_in = 0; row_out = 0; col_out = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_ENABLE: enable = val[0];
            REG_COLS: begin
               cols_reg = val[9:0];
               restart();
            end
            REG_ROWS: begin
               rows_reg = val[8:0];
               restart();
            end
            default: ;
         endcase
      endfunction

      function int unsigned addr_of(int unsigned r, int unsigned c);
         return (r * ncols() + c) % STORE_LEN;
      endfunction

      // weighted mean over the clipped window around (er,ec)
      function logic [15:0] smooth_at(int er, int ec);
         logic [16:0] cen, nb;
         logic [63:0] sw, swd, dd, key, idx, w;
         int r0, r1, c0, c1, dr, dc;
         cen = pix_mem[addr_of(er, ec)];
         if (!enable || !cen[16]) return cen[15:0];
         sw = 0; swd = 0;
         r0 = er - RAD < 0 ? 0 : er - RAD;
         r1 = er + RAD > int'(nrows()) - 1 ? int'(nrows()) - 1 : er + RAD;
         c0 = ec - RAD < 0 ? 0 : ec - RAD;
         c1 = ec + RAD > int'(ncols()) - 1 ? int'(ncols()) - 1 : ec + RAD;
         for (int k = r0; k <= r1; k++) begin
            for (int l = c0; l <= c1; l++) begin
               nb = pix_mem[addr_of(k, l)];
               if (nb[16]) begin
                  dr  = k - er;
                  dc  = l - ec;
                  dd  = nb[15:0] > cen[15:0] ? 64'(nb[15:0] - cen[15:0])
                                             : 64'(cen[15:0] - nb[15:0]);
                  key = 64'd100 * 64'(dr * dr + dc * dc) + dd * dd;
                  idx = (key * 64'(WT_DEPTH)) >> 15;
                  w   = idx < WT_DEPTH ? 64'(wt_rom[idx]) : 64'd0;
                  sw  = sw + w;
                  swd = swd + w * 64'(nb[15:0]);
               end
            end
         end
         if (sw == 0) return cen[15:0];
         return 16'((swd + sw / 2) / sw);
      endfunction

      function void note_input(dbf_req_type it);
         int unsigned lag, in_lin, e_lin;
         bit done;
         dbf_rsp_type r;
         done = input_done();
         if (it.action == ACT_PIXEL) begin
            if (done) return;
            pix_mem[addr_of(row_in, col_in)] = {it.valid_req, it.depth};
            col_in++;
            if (col_in >= ncols()) begin
               col_in = 0;
               row_in++;
            end
            done = input_done();
         end else if (!done) begin
            return;
         end
         lag    = RAD * ncols() + RAD;
         in_lin = row_in * ncols() + col_in;
         e_lin  = row_out * ncols() + col_out;
         if (!done && in_lin <= e_lin + lag) return;
         r.filtered_depth = smooth_at(row_out, col_out);
         r.out_row = ROW_W'(row_out);
         r.out_col = COL_W'(col_out);
         r.last    = (row_out == nrows() - 1) && (col_out == ncols() - 1);
         expected_pixels.push_back(r);
         if (r.last) begin
            restart();
            frames_done++;
         end else begin
            col_out++;
            if (col_out >= ncols()) begin
               col_out = 0;
               row_out++;
            end
         end
      endfunction

      function void check_result(dbf_rsp_type got);
         dbf_rsp_type exp_r;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         exp_r = expected_pixels.pop_front();
         if (got.filtered_depth !== exp_r.filtered_depth) begin
            $display("%0t: filtered_depth expected %0d actual %0d", $realtime,
                     exp_r.filtered_depth, got.filtered_depth);
            errors++;
         end
         if (got.out_row !== exp_r.out_row) begin
            $display("%0t: out_row expected %0d actual %0d", $realtime,
                     exp_r.out_row, got.out_row);
            errors++;
         end
         if (got.out_col !== exp_r.out_col) begin
            $display("%0t: out_col expected %0d actual %0d", $realtime,
                     exp_r.out_col, got.out_col);
            errors++;
         end
         if (got.last !== exp_r.last) begin
            $display("%0t: last expected %0d actual %0d", $realtime,
                     exp_r.last, got.last);
            errors++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, reset and block
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   dbf_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   dbf_rsp_type rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   filter_scoreboard board = new();

   int  cycles = 0;
   int  rand_sent = 0;
   bit  calm = 1'b0;        // no idling on either side while set
   bit  hold_req = 1'b0;    // asks the receiver for one long hold-off
   int  hold_left = 0;
   logic [15:0] depth_base;

   always #5 clock = ~clock;

   depth_bilateral_filter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: ready pattern changes on the falling edge
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = 3000;
         hold_req  = 1'b0;
      end
      if (reset) begin
         rsp_ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = calm || ($urandom_range(99) >= 34);
      end
   end

   // result transfer check at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      // register takes the value at this edge since pready is tied high
      @(posedge clock);
      board.set_reg(idx, val);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // offer one transfer, with a random gap in front of it
   task automatic send_item(dbf_req_type it);
      while (!calm && $urandom_range(99) < 34) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = it;
      do @(posedge clock); while (!req_ready);
      board.note_input(it);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // block is idle once nothing is owed and a result's latency has passed
   task automatic settle();
      wait (board.expected_pixels.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic dbf_req_type make_pixel();
      dbf_req_type it;
      it.action    = ACT_PIXEL;
      it.valid_req = $urandom_range(99) < 85;
      if ($urandom_range(99) < 88)
         it.depth = depth_base + 16'($urandom_range(80));
      else
         it.depth = 16'($urandom);
      return it;
   endfunction

   // stream one frame: pixels, then drains, with some noise mixed in;
   // cut_after > 0 stops the frame early (next register write aborts it)
   task automatic run_frame(bit counted, int cut_after);
      dbf_req_type it;
      int target, sent;
      target = board.frames_done + 1;
      sent   = 0;
      depth_base = 16'($urandom_range(65535 - 80));
      while (board.frames_done < target && (cut_after == 0 || sent < cut_after)) begin
         it = make_pixel();
         if (board.input_done()) begin
            // stray pixel after the frame is in is dropped
            if ($urandom_range(99) >= 8) it.action = ACT_DRAIN;
         end else if ($urandom_range(99) < 4) begin
            // early drain is dropped
            it.action = ACT_DRAIN;
         end
         send_item(it);
         sent++;
         if (counted) begin
            rand_sent++;
            calm = (rand_sent >= 400 && rand_sent < 650);
            if (rand_sent == 900) hold_req = 1'b1;
         end
      end
   endtask

   task automatic set_frame(int unsigned c, int unsigned r, bit en);
      settle();
      write_reg(REG_ENABLE, 32'(en));
      write_reg(REG_COLS, 32'(c));
      write_reg(REG_ROWS, 32'(r));
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      dbf_req_type it;
      logic [15:0] dir_depth [12];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: 4x3 frame, depth extremes, invalid centres, noise transfers
      dir_depth = '{16'd0, 16'hFFFF, 16'd1000, 16'd1010, 16'd1005, 16'd990,
                    16'd1000, 16'hFFFF, 16'd0, 16'd1020, 16'd995, 16'h8000};
      set_frame(4, 3, 1'b1);
      it = '{action: ACT_DRAIN, depth: 16'hFFFF, valid_req: 1'b1};
      send_item(it);
      for (int i = 0; i < 12; i++) begin
         it = '{action: ACT_PIXEL, depth: dir_depth[i], valid_req: (i % 5) != 3};
         send_item(it);
      end
      it = '{action: ACT_PIXEL, depth: 16'd1234, valid_req: 1'b1};
      send_item(it);
      while (board.frames_done < 1) begin
         it = '{action: ACT_DRAIN, depth: 16'd0, valid_req: 1'b0};
         send_item(it);
      end

      // register extremes: clamped widest row, tall column, zero width;
      // the two large frames are cut short to keep the item count in bounds
      set_frame(1023, 0, 1'b1);
      run_frame(1'b1, 700);
      set_frame(1, 480, 1'b1);
      run_frame(1'b1, 120);
      set_frame(0, 3, 1'b1);
      run_frame(1'b1, 0);
      set_frame(11, 11, 1'b1);
      run_frame(1'b1, 0);

      // random frames, some aborted part way by the next register write
      while (rand_sent < RAND_ITEMS) begin
         set_frame($urandom_range(1, 24), $urandom_range(1, 14),
                   $urandom_range(99) < 80);
         run_frame(1'b1, ($urandom_range(99) < 12) ? $urandom_range(1, 60) : 0);
      end
      calm = 1'b0;

      settle();
      if (board.errors == 0 && board.expected_pixels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
